@@ hw/rtl/hxp_pkg.sv @@
`timescale 1ns / 1ps

package hxp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned HALF_W = 16;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 8'h34;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [15:0] UPPER_RESET = 16'h0800;

  typedef enum logic [1:0] {
    EV_DATA   = 2'd0,
    EV_END    = 2'd1,
    EV_RELOAD = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic                valid;
    event_kind_t         kind;
    logic [ADDR_W-1:0]   addr;
    logic [HALF_W-1:0]   half;
    logic                last;
  } hxp_result_t;

  // '0'..'9' map directly, anything else is taken as an uppercase A..F digit
  function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = c - CH_SEVEN;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return c[3:0];
    end
    return d[3:0];
  endfunction

endpackage

@@ hw/rtl/hex_record_stream_parser_top.sv @@
`timescale 1ns / 1ps
// A result appears on out_* in the cycle after the character beat that causes it.
// Throughput: one character per cycle; the output register is reloaded in the same
// cycle it is drained, so in_tready stays high unless a result is held by out_tready.
// Reset (rst_n, synchronous, active low): parser idle until a start mark,
// started flag clear, upper address 0x0800, output empty.
module hex_record_stream_parser_top
  import hxp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] record_char
  input  logic        in_tuser,   // [0] first_of_record
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] write_address, [47:32] halfword
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data    // upper_address
);

  logic              accept;
  hxp_result_t       res;
  logic [15:0]       upper_r;
  logic              out_valid_r;
  event_kind_t       kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [HALF_W-1:0] half_r;
  logic              last_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  hxp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .rec_char   (in_tdata),
    .rec_first  (in_tuser),
    .upper_addr (upper_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= UPPER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      upper_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      kind_r <= res.kind;
      addr_r <= res.addr;
      half_r <= res.half;
      last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {half_r, addr_r};
  assign out_tuser  = kind_r;
  assign out_tlast  = last_r;

  a_event_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != EV_DATA |-> out_tdata == '0 && out_tlast)
    else $error("non-data event carries payload or lacks last");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == EV_DATA || out_tuser == EV_END || out_tuser == EV_RELOAD)
    else $error("undefined event kind on output");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> upper_r == $past(cfg_data))
    else $error("upper address not updated by config beat");

endmodule

@@ hw/rtl/hxp_core.sv @@
`timescale 1ns / 1ps

module hxp_core
  import hxp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CHAR_W-1:0] rec_char,
  input  logic              rec_first,
  input  logic [15:0]       upper_addr,
  output hxp_result_t       res
);

  localparam logic [POS_W-1:0] POS_IDLE    = '1;
  localparam logic [POS_W-1:0] POS_CNT_HI  = 10'd1;
  localparam logic [POS_W-1:0] POS_CNT_LO  = 10'd2;
  localparam logic [POS_W-1:0] POS_ADDR_HI = 10'd3;
  localparam logic [POS_W-1:0] POS_ADDR_LO = 10'd6;
  localparam logic [POS_W-1:0] POS_TYPE    = 10'd8;
  localparam logic [POS_W-1:0] POS_DATA    = 10'd9;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [15:0]      raddr_r, raddr_nxt;
  logic             data_en_r, data_en_nxt;
  logic             started_r, started_nxt;
  logic [11:0]      acc_r, acc_nxt;

  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_off;
  logic [7:0]       k;
  logic [7:0]       halves;
  logic [8:0]       k_plus;
  logic [1:0]       j;
  logic [3:0]       nib;

  assign pos_inc = pos_r + 10'd1;
  assign pos_off = pos_inc - POS_DATA;
  assign k       = pos_off[POS_W-1:2];
  assign j       = pos_off[1:0];
  assign halves  = {1'b0, count_r[7:1]};
  assign k_plus  = {1'b0, k} + 9'd1;
  assign nib     = hex_nibble(rec_char);

  always_comb begin
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    raddr_nxt   = raddr_r;
    data_en_nxt = data_en_r;
    started_nxt = started_r;
    acc_nxt     = acc_r;
    res         = '0;
    res.kind    = EV_DATA;
    if (accept) begin
      if (rec_first) begin
        pos_nxt     = '0;
        data_en_nxt = 1'b0;
      end else if (pos_r != POS_IDLE) begin
        pos_nxt = pos_inc;
        priority if (pos_inc == POS_IDLE) begin
          // record ran too long: park until the next start mark
        end else if (pos_inc == POS_CNT_HI) begin
          count_nxt = {4'd0, nib};
        end else if (pos_inc == POS_CNT_LO) begin
          count_nxt = {count_r[3:0], nib};
        end else if (pos_inc == POS_ADDR_HI) begin
          raddr_nxt = {12'd0, nib};
        end else if (pos_inc > POS_ADDR_HI && pos_inc <= POS_ADDR_LO) begin
          raddr_nxt = {raddr_r[11:0], nib};
        end else if (pos_inc == POS_TYPE) begin
          if (rec_char == CH_ONE) begin
            res.valid = 1'b1;
            res.kind  = EV_END;
            res.last  = 1'b1;
          end else if (rec_char == CH_FOUR) begin
            started_nxt = 1'b1;
          end else if (rec_char == CH_ZERO) begin
            if (started_r) begin
              data_en_nxt = 1'b1;
            end else begin
              res.valid = 1'b1;
              res.kind  = EV_RELOAD;
              res.last  = 1'b1;
            end
          end
        end else if (pos_inc >= POS_DATA && data_en_r) begin
          if (k >= halves) begin
            data_en_nxt = 1'b0;
          end else if (j == 2'd0) begin
            acc_nxt = {8'd0, nib};
          end else if (j != 2'd3) begin
            acc_nxt = {acc_r[7:0], nib};
          end else begin
            // four digits = two bytes; first byte goes to the low half
            res.valid = 1'b1;
            res.kind  = EV_DATA;
            res.half  = {acc_r[3:0], nib, acc_r[11:4]};
            res.addr  = {upper_addr, raddr_r} + {23'd0, k, 1'b0};
            res.last  = (k_plus == {1'b0, halves});
          end
        end else begin
          // position 7, or data characters with output disabled
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= POS_IDLE;
      count_r   <= '0;
      raddr_r   <= '0;
      data_en_r <= 1'b0;
      started_r <= 1'b0;
      acc_r     <= '0;
    end else begin
      pos_r     <= pos_nxt;
      count_r   <= count_nxt;
      raddr_r   <= raddr_nxt;
      data_en_r <= data_en_nxt;
      started_r <= started_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule
